>>> hw/rtl/lcsb_pkg.sv
// lcsb_pkg: shared types, sizes and register codes of the line camera smoothing block
// depends on nothing; imported by every module of the block
`default_nettype none

package lcsb_pkg;

    // line geometry
    localparam int LINE_PIXELS   = 128;
    localparam int BORDER_PIXELS = 5;
    localparam int PIX_W         = 8;
    localparam int CNT_W         = $clog2(LINE_PIXELS);
    localparam int SUM_W         = $clog2(LINE_PIXELS * 255 + 1);
    localparam int MEAN_SHIFT    = $clog2(LINE_PIXELS);
    localparam int LEFT_W        = $clog2(BORDER_PIXELS + 2);

    // q16 filter weights
    localparam int W_SIDE = 9830;
    localparam int W_MID  = 45875;
    localparam int ACC_W  = PIX_W + 16;

    // pixel counter landmarks
    localparam logic [CNT_W-1:0] CNT_ONE         = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FIRST_EMIT  = CNT_W'(BORDER_PIXELS + 1);
    localparam logic [CNT_W-1:0] CNT_SMOOTH_LAST = CNT_W'(LINE_PIXELS - BORDER_PIXELS);
    localparam logic [CNT_W-1:0] CNT_LAST        = CNT_W'(LINE_PIXELS - 1);
    localparam logic [CNT_W-1:0] POS_BORDER      = CNT_W'(BORDER_PIXELS);
    localparam logic [CNT_W-1:0] POS_EDGE        = CNT_W'(LINE_PIXELS - 1 - BORDER_PIXELS);

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [PIX_W-1:0] BINARY_THR_RST = 8'd230;
    localparam logic [PIX_W-1:0] HIGH_MEAN_RST  = 8'd220;
    localparam logic [PIX_W-1:0] BAND_LOW_RST   = 8'd200;

    typedef enum logic [1:0] {
        REG_BINARY_THR = 2'd0,
        REG_HIGH_MEAN  = 2'd1,
        REG_BAND_LOW   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] binary_threshold;
        logic [PIX_W-1:0] high_mean_threshold;
        logic [PIX_W-1:0] band_low_threshold;
    } t_cfg;

    // input word
    typedef struct packed {
        logic [PIX_W-1:0] near_pixel;
        logic [PIX_W-1:0] far_pixel;
    } t_pix;

    // result word
    typedef struct packed {
        logic [CNT_W-1:0] position;
        logic             near_bit;
        logic             far_bit;
        logic             line_done;
        logic             all_high;
        logic             mid_band;
    } t_res;

    // run of result words produced by one input word
    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  start;
        logic [LEFT_W-1:0] count;
        logic [PIX_W-1:0]  near_val;
        logic [PIX_W-1:0]  far_val;
        logic              done_last;
        logic [SUM_W-1:0]  sum;
    } t_burst;

endpackage

`default_nettype wire

>>> hw/rtl/lcsb_stream_if.sv
// lcsb_stream_if: valid/ready stream channel carrying one payload word
// payload type is set at instantiation; no package dependency
`default_nettype none

interface lcsb_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/line_ccd_smooth_binarize.sv
// Line camera smoothing and binarization. Each word on i_pix is one near/forward
// pixel pair of a 128-pixel scan; each word on o_res is one binarized pixel with
// its position, and the word for the last pixel carries line_done and the two
// near-mean flags. The recursive 3-tap filter is combinational between the
// input word register and the result word register, so a pair can be accepted
// every cycle outside the left border run and the last pair's run while o_res
// is ready. Pairs 0 to 5 give no word, pair 6 gives the six words for pixels 0
// to 5 and the last pair gives two; the result register plays a run out one
// word per cycle while o_res is ready and holds the next pair in the input
// register meanwhile, until the run's last word is taken. Thresholds are to be
// written over the APB port at byte addresses 0, 4 and 8 only while the stream
// is idle; the block itself does not enforce this.
// depends on lcsb_pkg, lcsb_stream_if, lcsb_cfg, lcsb_smooth, lcsb_emit
`default_nettype none

module line_ccd_smooth_binarize (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lcsb_stream_if.sink                        i_pix,
    lcsb_stream_if.source                      o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lcsb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lcsb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lcsb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import lcsb_pkg::*;

    t_cfg   w_cfg;
    t_burst w_burst;
    logic   w_can_load;

    // threshold registers
    lcsb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register and filter
    lcsb_smooth u_smooth (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_can_load (w_can_load),
        .o_burst    (w_burst)
    );

    // result register
    lcsb_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (w_burst),
        .i_cfg      (w_cfg),
        .o_can_load (w_can_load),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    // the line end marker only ever sits on the last pixel
    a_done_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.line_done |-> o_res.data.position == CNT_LAST)
        else $error("line_done on a position other than the last pixel");

    // mean flags stay low away from the line end
    a_flags_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.line_done
        |-> !o_res.data.all_high && !o_res.data.mid_band)
        else $error("mean flag raised before line end");

    // a run handed to the result register shows up on the next cycle
    a_run_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_burst.valid && w_can_load |=> o_res.valid)
        else $error("run accepted by result register but no word shown");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/lcsb_cfg.sv
// lcsb_cfg: apb register file holding the three thresholds
// depends on lcsb_pkg
`default_nettype none

module lcsb_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lcsb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lcsb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lcsb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output lcsb_pkg::t_cfg                     o_cfg
);
    import lcsb_pkg::*;

    logic [PIX_W-1:0] r_binary_thr;
    logic [PIX_W-1:0] r_high_mean;
    logic [PIX_W-1:0] r_band_low;
    t_reg_idx         w_idx;
    logic             w_write;

    assign w_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_thr <= BINARY_THR_RST;
            r_high_mean  <= HIGH_MEAN_RST;
            r_band_low   <= BAND_LOW_RST;
        end else if (w_write) begin
            unique case (w_idx)
                REG_BINARY_THR: r_binary_thr <= pwdata[PIX_W-1:0];
                REG_HIGH_MEAN:  r_high_mean  <= pwdata[PIX_W-1:0];
                REG_BAND_LOW:   r_band_low   <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (w_idx)
            REG_BINARY_THR: prdata = CFG_DATA_W'(r_binary_thr);
            REG_HIGH_MEAN:  prdata = CFG_DATA_W'(r_high_mean);
            REG_BAND_LOW:   prdata = CFG_DATA_W'(r_band_low);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.binary_threshold    = r_binary_thr;
    assign o_cfg.high_mean_threshold = r_high_mean;
    assign o_cfg.band_low_threshold  = r_band_low;

endmodule

`default_nettype wire

>>> hw/rtl/lcsb_smooth.sv
// lcsb_smooth: input word register, recursive 3-tap smoothing and line sum
// depends on lcsb_pkg and lcsb_stream_if; feeds lcsb_emit with at most one run per word
`default_nettype none

module lcsb_smooth (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lcsb_stream_if.sink          i_pix,
    input  logic                 i_can_load,
    output lcsb_pkg::t_burst     o_burst
);
    import lcsb_pkg::*;

    // truncated q16 weighted sum of three taps
    function automatic logic [PIX_W-1:0] smooth3(input logic [PIX_W-1:0] left,
                                                 input logic [PIX_W-1:0] mid,
                                                 input logic [PIX_W-1:0] right);
        logic [ACC_W-1:0] acc;
        acc = ACC_W'(W_SIDE) * (ACC_W'(left) + ACC_W'(right))
            + ACC_W'(W_MID) * ACC_W'(mid);
        return acc[16 +: PIX_W];
    endfunction

    logic             r_in_valid;
    logic [PIX_W-1:0] r_in_near;
    logic [PIX_W-1:0] r_in_far;
    logic [CNT_W-1:0] r_count;
    logic [PIX_W-1:0] r_prev_near, n_prev_near;
    logic [PIX_W-1:0] r_prev_far,  n_prev_far;
    logic [PIX_W-1:0] r_held_near, n_held_near;
    logic [PIX_W-1:0] r_held_far,  n_held_far;
    logic [PIX_W-1:0] r_edge_near, n_edge_near;
    logic [PIX_W-1:0] r_edge_far,  n_edge_far;
    logic [SUM_W-1:0] r_sum,       n_sum;

    logic             w_emit;
    logic             w_consume;
    logic             w_line_end;
    logic [CNT_W-1:0] w_pos;
    logic [PIX_W-1:0] w_sn;
    logic [PIX_W-1:0] w_sf;
    logic [SUM_W-1:0] w_add;

    // an item leaves the input register when its run is taken or it has none
    assign w_emit     = (r_count >= CNT_FIRST_EMIT);
    assign w_consume  = r_in_valid && (!w_emit || i_can_load);
    assign w_line_end = (r_count == CNT_LAST);
    assign i_pix.ready = !r_in_valid || w_consume;

    assign w_pos = r_count - CNT_ONE;
    assign w_sn  = smooth3(r_prev_near, r_held_near, r_in_near);
    assign w_sf  = smooth3(r_prev_far,  r_held_far,  r_in_far);

    // per-position filter state and run description
    always_comb begin
        n_prev_near = r_prev_near;
        n_prev_far  = r_prev_far;
        n_held_near = r_held_near;
        n_held_far  = r_held_far;
        n_edge_near = r_edge_near;
        n_edge_far  = r_edge_far;
        w_add       = '0;

        o_burst.start     = w_pos;
        o_burst.count     = LEFT_W'(1);
        o_burst.near_val  = w_sn;
        o_burst.far_val   = w_sf;
        o_burst.done_last = 1'b0;

        priority if (r_count == '0) begin
            n_prev_near = r_in_near;
            n_prev_far  = r_in_far;
            n_held_near = r_in_near;
            n_held_far  = r_in_far;
        end else if (r_count == CNT_ONE) begin
            n_held_near = r_in_near;
            n_held_far  = r_in_far;
        end else if (r_count <= CNT_SMOOTH_LAST) begin
            n_prev_near = w_sn;
            n_prev_far  = w_sf;
            n_held_near = r_in_near;
            n_held_far  = r_in_far;
            // left border pixels repeat the first fully smoothed one
            if (w_pos == POS_BORDER) begin
                o_burst.start = '0;
                o_burst.count = LEFT_W'(BORDER_PIXELS + 1);
                w_add = SUM_W'(w_sn) * SUM_W'(BORDER_PIXELS + 1);
            end else if (w_pos > POS_BORDER) begin
                w_add = SUM_W'(w_sn);
            end
            if (w_pos == POS_EDGE) begin
                n_edge_near = w_sn;
                n_edge_far  = w_sf;
            end
        end else begin
            // right border pixels repeat the last smoothed one
            o_burst.near_val = r_edge_near;
            o_burst.far_val  = r_edge_far;
            if (w_line_end) begin
                o_burst.count     = LEFT_W'(2);
                o_burst.done_last = 1'b1;
                w_add = SUM_W'(r_edge_near) + SUM_W'(r_edge_near);
            end else begin
                w_add = SUM_W'(r_edge_near);
            end
        end

        n_sum         = r_sum + w_add;
        o_burst.sum   = n_sum;
        o_burst.valid = r_in_valid && w_emit;
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.valid && i_pix.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in_near <= i_pix.data.near_pixel;
            r_in_far  <= i_pix.data.far_pixel;
        end
    end

    // line position and running near sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (w_consume) begin
            if (w_line_end) begin
                r_count <= '0;
                r_sum   <= '0;
            end else begin
                r_count <= r_count + CNT_ONE;
                r_sum   <= n_sum;
            end
        end
    end

    // filter taps, always written before they are read in a line
    always_ff @(posedge i_clk) begin
        if (w_consume) begin
            r_prev_near <= n_prev_near;
            r_prev_far  <= n_prev_far;
            r_held_near <= n_held_near;
            r_held_far  <= n_held_far;
            r_edge_near <= n_edge_near;
            r_edge_far  <= n_edge_far;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcsb_emit.sv
// lcsb_emit: result word register that plays out a run one word per handshake
// depends on lcsb_pkg and lcsb_stream_if; binarizes and forms the line flags
`default_nettype none

module lcsb_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcsb_pkg::t_burst     i_burst,
    input  lcsb_pkg::t_cfg       i_cfg,
    output logic                 o_can_load,
    lcsb_stream_if.source        o_res
);
    import lcsb_pkg::*;

    logic              r_valid;
    logic [CNT_W-1:0]  r_pos;
    logic [LEFT_W-1:0] r_left;
    logic [PIX_W-1:0]  r_near;
    logic [PIX_W-1:0]  r_far;
    logic              r_done_last;
    logic [SUM_W-1:0]  r_sum;

    logic              w_last_word;
    logic              w_fire;
    logic              w_load;
    logic              w_done;
    logic [PIX_W-1:0]  w_mean;

    assign w_last_word = (r_left == LEFT_W'(1));
    assign w_fire      = r_valid && o_res.ready;
    assign o_can_load  = !r_valid || (o_res.ready && w_last_word);
    assign w_load      = i_burst.valid && o_can_load;

    // run register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (w_fire && w_last_word) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pos       <= i_burst.start;
            r_left      <= i_burst.count;
            r_near      <= i_burst.near_val;
            r_far       <= i_burst.far_val;
            r_done_last <= i_burst.done_last;
            r_sum       <= i_burst.sum;
        end else if (w_fire) begin
            r_pos  <= r_pos + CNT_W'(1);
            r_left <= r_left - LEFT_W'(1);
        end
    end

    // binarize and mean flags
    assign w_done = r_done_last && w_last_word;
    assign w_mean = PIX_W'(r_sum >> MEAN_SHIFT);

    assign o_res.valid          = r_valid;
    assign o_res.data.position  = r_pos;
    assign o_res.data.near_bit  = (r_near > i_cfg.binary_threshold);
    assign o_res.data.far_bit   = (r_far > i_cfg.binary_threshold);
    assign o_res.data.line_done = w_done;
    assign o_res.data.all_high  = w_done && (w_mean > i_cfg.high_mean_threshold);
    assign o_res.data.mid_band  = w_done && (w_mean > i_cfg.band_low_threshold)
                                         && (w_mean < i_cfg.high_mean_threshold);

endmodule

`default_nettype wire
